// ===== hdl/video_output_camera_sequencer_top_macros.svh =====
// Assertion macros for the camera sequencer.
// Included by hdl/video_output_camera_sequencer_top.sv.
`ifndef VIDEO_OUTPUT_CAMERA_SEQUENCER_TOP_MACROS_SVH
`define VIDEO_OUTPUT_CAMERA_SEQUENCER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VOCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define VOCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/vocs_pkg.sv =====
// Package for the camera sequencer: constants, payload structs, state codes.
// No dependencies.
`timescale 1ns / 1ps
package vocs_pkg;
   localparam int NUM_CARDS_DEF   = 2;
   localparam int NUM_PORTS_DEF   = 4;
   localparam int NUM_CAMS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MODE_PORTS      = 8;
   localparam logic [15:0] ACT_HOLD_RST  = 16'd3000;
   localparam logic [15:0] INIT_DWELL_RST = 16'd5000;
   localparam logic [9:0]  MS_PER_S       = 10'd1000;

   localparam logic [2:0] CMD_START  = 3'd0;
   localparam logic [2:0] CMD_TICK   = 3'd1;
   localparam logic [2:0] CMD_ADD    = 3'd2;
   localparam logic [2:0] CMD_STATUS = 3'd3;
   localparam logic [2:0] CMD_STOP   = 3'd4;

   localparam logic [1:0] MODE_SEQ = 2'd1;
   localparam logic [1:0] MODE_ACT = 2'd2;

   localparam logic [1:0] CSR_PORT_MODES = 2'd0;
   localparam logic [1:0] CSR_ACT_HOLD   = 2'd1;
   localparam logic [1:0] CSR_INIT_DWELL = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] now_ms;
      logic        card;
      logic [3:0]  camera;
      logic        cam_active;
      logic [7:0]  dwell_s;
   } req_type;

   typedef struct packed {
      logic       out_card;
      logic [1:0] out_port;
      logic [3:0] out_camera;
      logic       switch_source;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PORT, ST_WALK, ST_DWELL, ST_SWITCH, ST_ACT, ST_ADD_SCAN,
      ST_STOP, ST_EMIT, ST_FLUSH
   } state_type;
endpackage

// ===== hdl/video_output_camera_sequencer_top.sv =====
// Camera sequencer top level: one sequencer that walks ports and cameras.
// Depends on vocs_pkg and video_output_camera_sequencer_top_macros.svh.
`timescale 1ns / 1ps
`include "video_output_camera_sequencer_top_macros.svh"
// Usage:
//  req_ channel: one command request (start, tick, add activity, camera status,
//  stop) per handshake, taken when req_valid is high and req_stall is low.
//  rsp_ channel: one result per port switch; the final switch of a tick has
//  last set. A tick that switches nothing produces no result.
//  csr_ channel: register writes by index (0 port modes, 1 activity hold,
//  2 initial dwell); write only while the block is idle.
//  Timing: the block handles one request at a time, stalling req_ meanwhile.
//  A tick visits every port in turn; a sequence port that is due counts the
//  active cameras in one pass, then walks the camera list one camera per cycle,
//  wrapping at most once, then passes through a dwell state for the dwell
//  multiply; add activity scans the queue one entry per cycle.
//  Each result waits in an output register; while rsp_stall is high the
//  sequencer holds until the register is free.
//  Reset: synchronous, active high; clears control state and per-port state.
//  No clearing pass is needed.
module video_output_camera_sequencer_top #(
   parameter int NUM_CARDS   = vocs_pkg::NUM_CARDS_DEF,
   parameter int NUM_PORTS   = vocs_pkg::NUM_PORTS_DEF,
   parameter int NUM_CAMS    = vocs_pkg::NUM_CAMS_DEF,
   parameter int QUEUE_DEPTH = vocs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vocs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vocs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   localparam int NP  = NUM_CARDS * NUM_PORTS;
   localparam int PW  = (NP > 1) ? $clog2(NP) : 1;
   localparam int CW  = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1;
   localparam int JW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int MW  = (NUM_CAMS > 1) ? $clog2(NUM_CAMS) : 1;
   localparam int NCAM = NUM_CARDS * NUM_CAMS;
   localparam int XW  = (NCAM > 1) ? $clog2(NCAM) : 1;
   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW  = $clog2(QUEUE_DEPTH + 1);
   localparam int WW  = $clog2(2 * NUM_CAMS + 1);
   localparam int NQ  = NUM_CARDS * QUEUE_DEPTH;
   localparam int AW  = (NQ > 1) ? $clog2(NQ) : 1;
   localparam int KW  = $clog2(NP + 1);
   localparam int CAMV = MW + 1;   // camera value plus a "none" flag bit

   // Registers and state
   vocs_pkg::state_type state_ff, state_in;
   vocs_pkg::req_type   req_ff, req_in;
   logic [15:0] modes_ff, modes_in, act_hold_ff, act_hold_in;
   logic [15:0] init_dwell_ff, init_dwell_in;
   logic [31:0] sw_time_ff [NP];
   logic [31:0] hold_ff [NP];
   logic [CAMV-1:0] cur_ff [NP];
   logic [NCAM-1:0] active_ff;
   logic [7:0] dwell_ff [NCAM];
   logic [MW-1:0] queue_mem [NQ];
   logic [FW-1:0] fill_ff [NUM_CARDS];
   logic [QW-1:0] head_ff [NUM_CARDS];
   logic running_ff, running_in;
   logic [PW-1:0] pidx_ff, pidx_in;
   logic [WW-1:0] wc_ff, wc_in;                   // walk step, 0..2*NUM_CAMS
   logic [MW:0] nact_ff, nact_in, seen_ff, seen_in; // active count, actives seen
   logic [CAMV-1:0] wcur_ff, wcur_in, first_ff, first_in;
   logic [MW-1:0] pick_ff, pick_in;
   logic [31:0] prod_ff;
   logic [KW-1:0] nres_ff, nres_in;
   logic [FW-1:0] scan_ff, scan_in;
   logic found_ff, found_in;
   vocs_pkg::rsp_type pend_ff, pend_in;   // result awaiting its last flag
   logic pend_v_ff, pend_v_in;
   vocs_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_v_ff, rsp_v_in;

   // Port-level controls from the sequencer to the state update
   typedef struct packed {
      logic start_all;
      logic stop_all;
      logic set_cur;
      logic seq_switch;
      logic act_switch;
      logic add_push;
      logic cam_write;
   } upd_type;
   upd_type upd;

   logic [CW-1:0] pcard;
   logic [CW-1:0] pcard_nx;
   logic [JW-1:0] pport;
   logic [1:0] pmode;
   logic [31:0] span;
   logic due_seq, due_act;
   logic [XW-1:0] wcam_idx;
   logic [MW-1:0] wcam;
   logic wact;
   logic [CW-1:0] rcard;
   logic [QW-1:0] qidx;
   logic [MW-1:0] qrd_ff;
   logic [AW-1:0] qaddr;
   logic push_ok;
   logic card_has_act;
   logic out_free;
   logic [CAMV-1:0] none_cam;

   assign none_cam  = {1'b1, {MW{1'b0}}};
   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign req_stall = (state_ff != vocs_pkg::ST_IDLE);
   assign csr_ready = (state_ff == vocs_pkg::ST_IDLE) && !req_valid;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // Current port decode
   always_comb begin
      pcard = CW'(32'(pidx_ff) / NUM_PORTS);
      pport = JW'(32'(pidx_ff) % NUM_PORTS);
      pmode = (32'(pidx_ff) < vocs_pkg::MODE_PORTS) ?
              2'(modes_ff >> (2 * 32'(pidx_ff))) : 2'd0;
      span  = req_ff.now_ms - sw_time_ff[pidx_ff];
      due_seq = (pmode == vocs_pkg::MODE_SEQ) && (span > hold_ff[pidx_ff]);
      due_act = (pmode == vocs_pkg::MODE_ACT) && (span > {16'd0, act_hold_ff});
      // first pass looks at wc_ff, the walk passes at wc_ff - NUM_CAMS
      wcam  = (32'(wc_ff) < NUM_CAMS) ? MW'(wc_ff) : MW'(32'(wc_ff) - NUM_CAMS);
      wcam_idx = XW'(32'(pcard) * NUM_CAMS + 32'(wcam));
      wact  = active_ff[wcam_idx];
      rcard = CW'(req_ff.card);
   end

   // Queue read address: activity pops use the port's card, adds scan the request card
   always_comb begin
      pcard_nx = CW'(32'(pidx_in) / NUM_PORTS);
      card_has_act = 1'b0;
      for (int j = 0; j < NUM_PORTS; j++) begin
         if ((32'(rcard) * NUM_PORTS + j) < vocs_pkg::MODE_PORTS &&
             2'(modes_ff >> (2 * (32'(rcard) * NUM_PORTS + j))) == vocs_pkg::MODE_ACT)
            card_has_act = 1'b1;
      end
      if (state_ff == vocs_pkg::ST_ADD_SCAN)
         qidx = QW'((32'(head_ff[rcard]) + 32'(scan_ff)) % QUEUE_DEPTH);
      else
         qidx = head_ff[pcard_nx];
      qaddr = AW'(32'((state_ff == vocs_pkg::ST_ADD_SCAN) ? rcard : pcard_nx)
                  * QUEUE_DEPTH + 32'(qidx));
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      pidx_in = pidx_ff;
      wc_in = wc_ff;
      nact_in = nact_ff;
      seen_in = seen_ff;
      wcur_in = wcur_ff;
      first_in = first_ff;
      pick_in = pick_ff;
      nres_in = nres_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      pend_in = pend_ff;
      pend_v_in = pend_v_ff;
      rsp_in = rsp_ff;
      rsp_v_in = rsp_v_ff && rsp_stall;
      running_in = running_ff;
      push_ok = 1'b0;
      upd = '0;
      unique case (state_ff)
         vocs_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               pidx_in = '0;
               scan_in = '0;
               found_in = 1'b0;
               nres_in = '0;
               pend_v_in = 1'b0;
               case (req_data.command)
                  vocs_pkg::CMD_START: begin
                     upd.start_all = 1'b1;
                     running_in = 1'b1;
                  end
                  vocs_pkg::CMD_TICK: begin
                     if (running_ff) state_in = vocs_pkg::ST_PORT;
                  end
                  vocs_pkg::CMD_ADD: begin
                     if (running_ff && 32'(req_data.card) < NUM_CARDS &&
                         32'(req_data.camera) < NUM_CAMS)
                        state_in = vocs_pkg::ST_ADD_SCAN;
                  end
                  vocs_pkg::CMD_STATUS: begin
                     if (32'(req_data.card) < NUM_CARDS &&
                         32'(req_data.camera) < NUM_CAMS)
                        upd.cam_write = 1'b1;
                  end
                  vocs_pkg::CMD_STOP: begin
                     upd.stop_all = 1'b1;
                     running_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         vocs_pkg::ST_PORT: begin
            wc_in = '0;
            nact_in = '0;
            seen_in = '0;
            wcur_in = cur_ff[pidx_ff];
            first_in = none_cam;
            if (32'(nres_ff) < NP && due_seq)
               state_in = vocs_pkg::ST_WALK;
            else if (32'(nres_ff) < NP && due_act && fill_ff[pcard] != '0)
               state_in = vocs_pkg::ST_ACT;
            else
               state_in = vocs_pkg::ST_SWITCH;
         end
         vocs_pkg::ST_WALK: begin
            // first pass counts actives, second pass walks
            if (32'(wc_ff) < NUM_CAMS) begin
               if (wact) nact_in = nact_ff + 1'b1;
               wc_in = wc_ff + 1'b1;
            end else if (nact_ff == '0 || 32'(wc_ff) >= 2 * NUM_CAMS) begin
               upd.set_cur = 1'b1;
               state_in = vocs_pkg::ST_SWITCH;
            end else begin
               wc_in = wc_ff + 1'b1;
               if (wact) begin
                  if (first_ff == none_cam) first_in = {1'b0, wcam};
                  if (wcur_ff == none_cam) begin
                     wcur_in = {1'b0, wcam};
                     pick_in = wcam;
                     upd.set_cur = 1'b1;
                     state_in = vocs_pkg::ST_DWELL;
                  end else if (wcur_ff == {1'b0, wcam}) begin
                     wcur_in = none_cam;
                     if (seen_ff + 1'b1 == nact_ff) wc_in = WW'(NUM_CAMS);
                  end
                  seen_in = seen_ff + 1'b1;
               end else if (wcur_ff == {1'b0, wcam}) begin
                  wcur_in = first_ff;
               end else begin
                  first_in = none_cam;
               end
            end
         end
         vocs_pkg::ST_DWELL: begin
            state_in = vocs_pkg::ST_EMIT;
         end
         vocs_pkg::ST_EMIT: begin
            // move a finished switch toward the output register
            if (prod_ff != '0 || req_ff.command != vocs_pkg::CMD_TICK) begin
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     rsp_in = pend_ff;
                     rsp_v_in = 1'b1;
                  end
                  pend_in = '{out_card: 1'(pcard), out_port: 2'(pport),
                              out_camera: 4'(wcur_ff), switch_source: 1'b0,
                              last: 1'b0};
                  pend_v_in = 1'b1;
                  nres_in = nres_ff + 1'b1;
                  upd.seq_switch = 1'b1;
                  state_in = vocs_pkg::ST_SWITCH;
               end
            end else begin
               state_in = vocs_pkg::ST_SWITCH;
            end
         end
         vocs_pkg::ST_ACT: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  rsp_in = pend_ff;
                  rsp_v_in = 1'b1;
               end
               pend_in = '{out_card: 1'(pcard), out_port: 2'(pport),
                           out_camera: 4'(qrd_ff), switch_source: 1'b1, last: 1'b0};
               pend_v_in = 1'b1;
               nres_in = nres_ff + 1'b1;
               upd.act_switch = 1'b1;
               state_in = vocs_pkg::ST_SWITCH;
            end
         end
         vocs_pkg::ST_SWITCH: begin
            if (32'(pidx_ff) == NP - 1) state_in = vocs_pkg::ST_FLUSH;
            else begin
               pidx_in = pidx_ff + 1'b1;
               state_in = vocs_pkg::ST_PORT;
            end
         end
         vocs_pkg::ST_FLUSH: begin
            if (!pend_v_ff) state_in = vocs_pkg::ST_IDLE;
            else if (out_free) begin
               rsp_in = pend_ff;
               rsp_in.last = 1'b1;
               rsp_v_in = 1'b1;
               pend_v_in = 1'b0;
               state_in = vocs_pkg::ST_IDLE;
            end
         end
         vocs_pkg::ST_ADD_SCAN: begin
            // one queued entry per cycle; the registered read data holds the entry at the previous index
            if (scan_ff != '0 && qrd_ff == req_ff.camera) found_in = 1'b1;
            if (scan_ff >= fill_ff[rcard]) begin
               push_ok = card_has_act && !found_in &&
                         32'(fill_ff[rcard]) < QUEUE_DEPTH;
               upd.add_push = push_ok;
               state_in = vocs_pkg::ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: state_in = vocs_pkg::ST_IDLE;
      endcase
      if (state_ff == vocs_pkg::ST_IDLE) begin
         // idle state keeps nothing pending
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vocs_pkg::ST_IDLE;
         running_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         running_ff <= running_in;
         rsp_v_ff <= rsp_v_in;
         pend_v_ff <= pend_v_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      pidx_ff <= pidx_in;
      wc_ff <= wc_in;
      nact_ff <= nact_in;
      seen_ff <= seen_in;
      wcur_ff <= wcur_in;
      first_ff <= first_in;
      pick_ff <= pick_in;
      nres_ff <= nres_in;
      scan_ff <= scan_in;
      found_ff <= found_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
      // shared multiplier: dwell seconds to milliseconds
      prod_ff <= 32'(dwell_ff[XW'(32'(pcard) * NUM_CAMS + 32'(pick_ff))]) *
                 32'(vocs_pkg::MS_PER_S);
   end

   // Queue memory: registered read, single write
   always_ff @(posedge clock) begin
      qrd_ff <= queue_mem[qaddr];
      if (upd.add_push)
         queue_mem[AW'(32'(rcard) * QUEUE_DEPTH +
                   (32'(head_ff[rcard]) + 32'(fill_ff[rcard])) % QUEUE_DEPTH)]
            <= MW'(req_ff.camera);
   end

   // Configuration registers
   always_comb begin
      modes_in = modes_ff;
      act_hold_in = act_hold_ff;
      init_dwell_in = init_dwell_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vocs_pkg::CSR_PORT_MODES: modes_in = csr_data;
            vocs_pkg::CSR_ACT_HOLD:   act_hold_in = csr_data;
            vocs_pkg::CSR_INIT_DWELL: init_dwell_in = csr_data;
            default: ;
         endcase
      end
   end

   // Per-port, per-camera and queue state
   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff <= '0;
         act_hold_ff <= vocs_pkg::ACT_HOLD_RST;
         init_dwell_ff <= vocs_pkg::INIT_DWELL_RST;
         active_ff <= '0;
         for (int p = 0; p < NP; p++) begin
            sw_time_ff[p] <= '0;
            hold_ff[p] <= {16'd0, vocs_pkg::INIT_DWELL_RST};
            cur_ff[p] <= {1'b1, {MW{1'b0}}};
         end
         for (int x = 0; x < NCAM; x++) dwell_ff[x] <= '0;
         for (int c = 0; c < NUM_CARDS; c++) begin
            fill_ff[c] <= '0;
            head_ff[c] <= '0;
         end
      end else begin
         modes_ff <= modes_in;
         act_hold_ff <= act_hold_in;
         init_dwell_ff <= init_dwell_in;
         if (csr_valid && csr_ready && csr_index == vocs_pkg::CSR_INIT_DWELL)
            for (int p = 0; p < NP; p++) hold_ff[p] <= {16'd0, csr_data};
         if (upd.start_all)
            for (int p = 0; p < NP; p++) sw_time_ff[p] <= req_data.now_ms;
         if (upd.stop_all) begin
            for (int p = 0; p < NP; p++) begin
               sw_time_ff[p] <= '0;
               cur_ff[p] <= {1'b1, {MW{1'b0}}};
            end
            for (int c = 0; c < NUM_CARDS; c++) begin
               fill_ff[c] <= '0;
               head_ff[c] <= '0;
            end
         end
         if (upd.cam_write) begin
            active_ff[XW'(32'(req_data.card) * NUM_CAMS + 32'(req_data.camera))]
               <= req_data.cam_active;
            dwell_ff[XW'(32'(req_data.card) * NUM_CAMS + 32'(req_data.camera))]
               <= req_data.dwell_s;
         end
         if (upd.set_cur) cur_ff[pidx_ff] <= wcur_in;
         if (upd.seq_switch) begin
            sw_time_ff[pidx_ff] <= req_ff.now_ms;
            hold_ff[pidx_ff] <= prod_ff;
         end
         if (upd.act_switch) begin
            sw_time_ff[pidx_ff] <= req_ff.now_ms;
            head_ff[pcard] <= QW'((32'(head_ff[pcard]) + 1) % QUEUE_DEPTH);
            fill_ff[pcard] <= fill_ff[pcard] - 1'b1;
         end
         if (upd.add_push) fill_ff[rcard] <= fill_ff[rcard] + 1'b1;
      end
   end

   // Checks
   `VOCS_ASSERT_IMP(a_rsp_hold, clock, reset, rsp_v_ff && rsp_stall && state_ff != vocs_pkg::ST_IDLE, rsp_v_in, "result dropped while stalled")
   `VOCS_ASSERT_IMP(a_fill_range, clock, reset, 1'b1, 32'(fill_ff[0]) <= QUEUE_DEPTH, "queue fill beyond depth")
   `VOCS_ASSERT_NEXT(a_idle_no_pend, clock, reset, state_ff == vocs_pkg::ST_FLUSH && state_in == vocs_pkg::ST_IDLE, !pend_v_ff, "pending result left behind")
   `VOCS_ASSERT_IMP(a_no_csr_busy, clock, reset, state_ff != vocs_pkg::ST_IDLE, !csr_ready, "config taken while busy")
endmodule
